// File: src/bgcd_pkg.sv
package bgcd_pkg;

  // ADC resolution and millisecond timer width
  localparam int AdcBits  = 12;
  localparam int TimeBits = 32;

  // port field widths
  localparam int SampleW  = 12;
  localparam int TimeW    = 32;
  localparam int MvW      = 14;
  localparam int RefW     = 13;
  localparam int RatioW   = 4;
  localparam int MsW      = 16;
  localparam int PctW     = 7;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  // serial gauge datapath
  localparam int McandW = RefW + RatioW;        // reference * ratio
  localparam int NumW   = MvW + PctW;           // (mv - empty) * 100, below span * 128
  localparam int DvsW   = MvW + PctW - 1;       // span aligned to the top quotient bit
  localparam int StepW  = $clog2((AdcBits > PctW) ? AdcBits : PctW);

  localparam logic [PctW-1:0] PctMax = PctW'(100);

  // register reset values
  localparam logic [MvW-1:0]    EmptyRst   = MvW'(2800);
  localparam logic [MvW-1:0]    FullRst    = MvW'(4100);
  localparam logic [RefW-1:0]   RefRst     = RefW'(3300);
  localparam logic [RatioW-1:0] RatioRst   = RatioW'(3);
  localparam logic [MsW-1:0]    PeriodRst  = MsW'(1000);
  localparam logic [MsW-1:0]    ReleaseRst = MsW'(3000);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_EMPTY,
    CFG_FULL,
    CFG_REF,
    CFG_RATIO,
    CFG_PERIOD,
    CFG_RELEASE
  } cfg_idx_e;

  typedef struct packed {
    logic [MvW-1:0]    empty_mv;
    logic [MvW-1:0]    full_mv;
    logic [RefW-1:0]   ref_mv;
    logic [RatioW-1:0] ratio;
    logic [MsW-1:0]    period_ms;
    logic [MsW-1:0]    release_ms;
  } bgcd_cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } bgcd_gstat_t;

endpackage

// File: src/battery_gauge_charge_detect.sv
// Battery gauge and charger detect, one input word per display frame.
// Input channel (in_valid_i/in_ready_o): time stamp, supply-detect and
// charger status pins, raw ADC sample. Output channel (out_valid_o/
// out_ready_i): one word per input word, the debounced charging flag and
// the battery percent. Config channel (cfg_valid_i/cfg_ready_o) is always
// ready; cfg_index_i selects empty, full, reference, divider ratio, sample
// period and release time. Indexes past the list are ignored.
// Path: accept, evaluate, then the output register when no percent update
// is due; when one is due, a bit-serial multiply, a setup step and a
// bit-serial divide come between; a clamped or zero percent skips the
// divide. One word is in flight at a time, so a new word is not taken
// until the last one's result sits in the output register, so a stalled
// receiver holds back only the word after that one.
// Reset clears all state and loads default config; the first word after
// reset seeds the charging flag, the release timer, the sample deadline and
// the percent from that word's pins and sample.
module battery_gauge_charge_detect (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [bgcd_pkg::TimeW-1:0]    time_ms_i,
  input  logic                          vbus_present_i,
  input  logic                          stat_pin_i,
  input  logic [bgcd_pkg::SampleW-1:0]  adc_sample_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          charging_o,
  output logic [bgcd_pkg::PctW-1:0]     percent_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bgcd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [bgcd_pkg::CfgDataW-1:0] cfg_data_i
);
  import bgcd_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_GAUGE,
    S_OUT
  } state_e;

  state_e              state_q;
  logic                started_q;
  logic                prev_low_q;
  logic                charging_q;
  logic [PctW-1:0]     percent_q;
  logic [TimeBits-1:0] last_low_q;
  logic [TimeBits-1:0] next_q;

  logic [TimeBits-1:0] time_q;
  logic                vbus_q;
  logic                stat_q;
  logic [AdcBits-1:0]  adc_q;

  logic                out_valid_q;
  logic                out_charging_q;
  logic [PctW-1:0]     out_percent_q;

  bgcd_cfg_t           cfg_q;

  logic                low;
  logic [TimeBits-1:0] elapsed;
  logic [TimeBits-1:0] lag;
  logic [TimeBits-1:0] next_d;
  logic                rel_hit;
  logic                due;
  logic                gauge_start;
  logic                out_load;
  bgcd_gstat_t         gstat;
  logic [PctW-1:0]     gauge_pct;

  assign low     = vbus_q & ~stat_q;
  // a charge-low word restarts the release timer before the test
  assign elapsed = low ? '0 : (time_q - last_low_q);
  assign rel_hit = elapsed >= TimeBits'(cfg_q.release_ms);
  // deadline passed when time - deadline lands in the lower half of the ring
  assign lag     = time_q - next_q;
  assign due     = ~lag[TimeBits-1];
  assign next_d  = time_q + TimeBits'(cfg_q.period_ms);

  assign gauge_start = (state_q == S_EVAL) && (!started_q || due);
  assign out_load    = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  bgcd_gauge u_gauge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (gauge_start),
    .sample_i (adc_q),
    .cfg_i    (cfg_q),
    .stat_o   (gstat),
    .pct_o    (gauge_pct)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.empty_mv   <= EmptyRst;
      cfg_q.full_mv    <= FullRst;
      cfg_q.ref_mv     <= RefRst;
      cfg_q.ratio      <= RatioRst;
      cfg_q.period_ms  <= PeriodRst;
      cfg_q.release_ms <= ReleaseRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_EMPTY:   cfg_q.empty_mv   <= cfg_data_i[MvW-1:0];
        CFG_FULL:    cfg_q.full_mv    <= cfg_data_i[MvW-1:0];
        CFG_REF:     cfg_q.ref_mv     <= cfg_data_i[RefW-1:0];
        CFG_RATIO:   cfg_q.ratio      <= cfg_data_i[RatioW-1:0];
        CFG_PERIOD:  cfg_q.period_ms  <= cfg_data_i[MsW-1:0];
        CFG_RELEASE: cfg_q.release_ms <= cfg_data_i[MsW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      started_q      <= 1'b0;
      prev_low_q     <= 1'b0;
      charging_q     <= 1'b0;
      percent_q      <= '0;
      last_low_q     <= '0;
      next_q         <= '0;
      time_q         <= '0;
      vbus_q         <= 1'b0;
      stat_q         <= 1'b0;
      adc_q          <= '0;
      out_valid_q    <= 1'b0;
      out_charging_q <= 1'b0;
      out_percent_q  <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            time_q  <= time_ms_i[TimeBits-1:0];
            vbus_q  <= vbus_present_i;
            stat_q  <= stat_pin_i;
            adc_q   <= adc_sample_i[AdcBits-1:0];
            state_q <= S_EVAL;
          end
        end
        S_EVAL: begin
          prev_low_q <= low;
          if (!started_q || low) begin
            last_low_q <= time_q;
          end
          if (!started_q) begin
            started_q  <= 1'b1;
            charging_q <= low;
          end else if (!charging_q) begin
            if (low && prev_low_q) begin
              charging_q <= 1'b1;
            end
          end else if (!vbus_q || rel_hit) begin
            charging_q <= 1'b0;
          end
          if (gauge_start) begin
            next_q  <= next_d;
            state_q <= S_GAUGE;
          end else begin
            state_q <= S_OUT;
          end
        end
        S_GAUGE: begin
          if (gstat.done) begin
            percent_q <= gauge_pct;
            state_q   <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            out_charging_q <= charging_q;
            out_percent_q  <= percent_q;
            state_q        <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign charging_o  = out_charging_q;
  assign percent_o   = out_percent_q;

  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    percent_q <= PctMax)
    else $error("percent out of range");

  a_set_needs_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(charging_q) |-> prev_low_q)
    else $error("charging set without a charge-low tick");

  a_gauge_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_GAUGE) |-> gstat.busy)
    else $error("waiting on an idle gauge");

  a_gauge_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !gstat.busy)
    else $error("gauge busy while ready for input");

endmodule

// File: src/bgcd_gauge.sv
module bgcd_gauge (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [bgcd_pkg::AdcBits-1:0] sample_i,
  input  bgcd_pkg::bgcd_cfg_t          cfg_i,
  output bgcd_pkg::bgcd_gstat_t        stat_o,
  output logic [bgcd_pkg::PctW-1:0]    pct_o
);
  import bgcd_pkg::*;

  typedef enum logic [2:0] {
    G_IDLE,
    G_MUL,
    G_PREP,
    G_DIV,
    G_DONE
  } state_e;

  state_e              state_q;
  logic [StepW-1:0]    cnt_q;
  logic [McandW-1:0]   mcand_q;
  logic [McandW-1:0]   hi_q;
  logic [AdcBits-1:0]  lo_q;
  logic [NumW-1:0]     rem_q;
  logic [DvsW-1:0]     dvs_q;
  logic [PctW-1:0]     quo_q;

  logic [McandW:0]     sum;
  logic [McandW-1:0]   empty_ext;
  logic [McandW-1:0]   diff;
  logic [MvW-1:0]      span;
  logic                span_ok;
  logic                mv_ok;
  logic                sat;
  logic [NumW-1:0]     diff_n;
  logic [NumW-1:0]     num;
  logic                ge;
  logic [NumW-1:0]     rem_sub;

  // shift-add multiply, one sample bit per cycle; hi_q ends as the millivolt value
  assign sum = {1'b0, hi_q} + {1'b0, (lo_q[0] ? mcand_q : '0)};

  assign empty_ext = McandW'(cfg_i.empty_mv);
  assign span_ok   = cfg_i.full_mv > cfg_i.empty_mv;
  assign mv_ok     = hi_q > empty_ext;
  assign diff      = hi_q - empty_ext;
  assign span      = cfg_i.full_mv - cfg_i.empty_mv;
  assign sat       = diff >= McandW'(span);

  // diff * 100 = diff * (64 + 32 + 4), only taken when diff < span
  assign diff_n = NumW'(diff[MvW-1:0]);
  assign num    = (diff_n << 6) + (diff_n << 5) + (diff_n << 2);

  // restoring divide, one quotient bit per cycle
  assign ge      = rem_q >= NumW'(dvs_q);
  assign rem_sub = rem_q - NumW'(dvs_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= G_IDLE;
      cnt_q   <= '0;
      mcand_q <= '0;
      hi_q    <= '0;
      lo_q    <= '0;
      rem_q   <= '0;
      dvs_q   <= '0;
      quo_q   <= '0;
    end else begin
      unique case (state_q)
        G_IDLE: begin
          if (start_i) begin
            mcand_q <= McandW'(cfg_i.ref_mv) * McandW'(cfg_i.ratio);
            hi_q    <= '0;
            lo_q    <= sample_i;
            cnt_q   <= '0;
            state_q <= G_MUL;
          end
        end
        G_MUL: begin
          hi_q  <= sum[McandW:1];
          lo_q  <= {sum[0], lo_q[AdcBits-1:1]};
          cnt_q <= cnt_q + StepW'(1);
          if (cnt_q == StepW'(AdcBits - 1)) begin
            state_q <= G_PREP;
          end
        end
        G_PREP: begin
          priority if (!span_ok || !mv_ok) begin
            quo_q   <= '0;
            state_q <= G_DONE;
          end else if (sat) begin
            quo_q   <= PctMax;
            state_q <= G_DONE;
          end else begin
            rem_q   <= num;
            dvs_q   <= DvsW'(span) << (PctW - 1);
            quo_q   <= '0;
            cnt_q   <= '0;
            state_q <= G_DIV;
          end
        end
        G_DIV: begin
          quo_q <= {quo_q[PctW-2:0], ge};
          if (ge) begin
            rem_q <= rem_sub;
          end
          dvs_q <= dvs_q >> 1;
          cnt_q <= cnt_q + StepW'(1);
          if (cnt_q == StepW'(PctW - 1)) begin
            state_q <= G_DONE;
          end
        end
        G_DONE: begin
          state_q <= G_IDLE;
        end
        default: begin
          state_q <= G_IDLE;
        end
      endcase
    end
  end

  assign stat_o.busy = state_q != G_IDLE;
  assign stat_o.done = state_q == G_DONE;
  assign pct_o       = quo_q;

endmodule
